### rtl/rsaf_pkg.sv
package rsaf_pkg;

  localparam int PREVIEW_SLOTS_DEF = 8;
  localparam int ID_BITS_DEF       = 64;
  localparam int COUNT_BITS_DEF    = 32;

  // Input command codes.
  localparam logic [3:0] CMD_LINK_BIND    = 4'd0;
  localparam logic [3:0] CMD_ARM          = 4'd1;
  localparam logic [3:0] CMD_MANIFEST     = 4'd2;
  localparam logic [3:0] CMD_PAYLOAD      = 4'd3;
  localparam logic [3:0] CMD_STREAM_OPEN  = 4'd4;
  localparam logic [3:0] CMD_CAPTURE      = 4'd5;
  localparam logic [3:0] CMD_SESSION_OPEN = 4'd6;
  localparam logic [3:0] CMD_OTHER        = 4'd7;
  localparam logic [3:0] CMD_BEGIN        = 4'd8;
  localparam logic [3:0] CMD_FINISH       = 4'd9;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_DECODE  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic search_start;
    logic commit;
  } rsaf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_search;
    logic search_done;
  } rsaf_stat_t;

endpackage

### rtl/rsaf_ram.sv
module rsaf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/rsaf_ctrl.sv
module rsaf_ctrl
  import rsaf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  rsaf_stat_t stat,
  output rsaf_cmd_t  ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SEARCH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EVAL;
            busy  <= 1'b1;
          end
        end
        S_EVAL: begin
          if (stat.need_search) begin
            state <= S_SEARCH;
          end else begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        S_SEARCH: begin
          if (stat.search_done) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  assign ctl.load         = (state == S_IDLE) && start;
  assign ctl.search_start = (state == S_EVAL) && stat.need_search;
  assign ctl.commit       = ((state == S_EVAL) && !stat.need_search) ||
                            ((state == S_SEARCH) && stat.search_done);

endmodule

### rtl/rsaf_dp.sv
module rsaf_dp
  import rsaf_pkg::*;
#(
  parameter int PREVIEW_SLOTS = PREVIEW_SLOTS_DEF,
  parameter int ID_BITS       = ID_BITS_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [3:0]  command,
  input  logic        decode_ok,
  input  logic        is_preview,
  input  logic        arb_params,
  input  logic [63:0] object_id,
  input  rsaf_cmd_t   ctl,
  output rsaf_stat_t  stat,
  output logic [1:0]  status,
  output logic [31:0] frame_total,
  output logic        manifest_admitted,
  output logic        is_hostless,
  output logic        done
);

  localparam int UW = $clog2(PREVIEW_SLOTS + 1);
  localparam int AW = (PREVIEW_SLOTS > 1) ? $clog2(PREVIEW_SLOTS) : 1;

  // Item registers.
  logic [3:0]         cmd_q;
  logic               ok_q;
  logic               prev_q;
  logic               arb_q;
  logic [ID_BITS-1:0] id_q;

  // Session state.
  logic                  started;
  logic                  closed;
  logic                  manifest_flag;
  logic                  session_open_seen;
  logic                  hostless_flag;
  logic [COUNT_BITS-1:0] count;
  logic [UW-1:0]         used;

  // Preview table search.
  logic [UW-1:0]      rd_idx;
  logic               searching;
  logic               pend;
  logic               hit;
  logic [ID_BITS-1:0] rdata;
  logic               issue;

  logic       in_session;
  logic       is_frame;
  logic       need_search;
  logic       ram_we;
  logic [1:0] quick;
  logic [1:0] verdict;

  assign in_session  = started && !closed;
  assign is_frame    = (cmd_q <= CMD_OTHER);
  assign need_search = in_session && (cmd_q == CMD_CAPTURE) && (used != '0) && ok_q;
  assign issue       = searching && (rd_idx < used);

  assign stat.need_search = need_search;
  assign stat.search_done = searching && !issue && !pend;

  always_comb begin
    quick = ST_REFUSED;
    unique case (cmd_q) inside
      CMD_BEGIN:  quick = started ? ST_REFUSED : ST_OK;
      CMD_FINISH: quick = started ? ST_OK : ST_REFUSED;
      [CMD_LINK_BIND:CMD_OTHER]: begin
        if (!in_session) begin
          quick = ST_REFUSED;
        end else begin
          unique case (cmd_q)
            CMD_LINK_BIND:    quick = ST_REFUSED;
            CMD_ARM:          quick = hostless_flag ? ST_REFUSED : ST_OK;
            CMD_MANIFEST:     quick = ST_OK;
            CMD_PAYLOAD:      quick = manifest_flag ? ST_OK : ST_REFUSED;
            CMD_STREAM_OPEN:  quick = ok_q ? ST_OK : ST_DECODE;
            // An empty preview table admits the announce whatever the body.
            CMD_CAPTURE:      quick = ((used == '0) || ok_q) ? ST_OK : ST_DECODE;
            CMD_SESSION_OPEN: quick = ok_q ? ST_OK : ST_DECODE;
            CMD_OTHER:        quick = ST_OK;
            default:          quick = ST_REFUSED;
          endcase
        end
      end
      default: quick = ST_REFUSED;
    endcase
  end

  assign verdict = need_search ? (hit ? ST_REFUSED : ST_OK) : quick;

  assign ram_we = ctl.commit && in_session && (cmd_q == CMD_STREAM_OPEN) && ok_q &&
                  prev_q && (used < UW'(PREVIEW_SLOTS));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q  <= command;
      ok_q   <= decode_ok;
      prev_q <= is_preview;
      arb_q  <= arb_params;
      id_q   <= object_id[ID_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started           <= 1'b0;
      closed            <= 1'b0;
      manifest_flag     <= 1'b0;
      session_open_seen <= 1'b0;
      hostless_flag     <= 1'b0;
      count             <= '0;
      used              <= '0;
    end else if (ctl.commit) begin
      if ((cmd_q == CMD_BEGIN) && (verdict == ST_OK)) begin
        started <= 1'b1;
      end
      if ((cmd_q == CMD_FINISH) && (verdict == ST_OK)) begin
        closed <= 1'b1;
      end
      if (in_session && (cmd_q == CMD_MANIFEST)) begin
        manifest_flag <= 1'b1;
      end
      if (in_session && (cmd_q == CMD_SESSION_OPEN) && ok_q) begin
        session_open_seen <= 1'b1;
        hostless_flag     <= !arb_q;
      end
      if (ram_we) begin
        used <= used + UW'(1);
      end
      if (is_frame && (verdict == ST_OK)) begin
        count <= count + COUNT_BITS'(1);
      end
    end
  end

  // Reads are issued one entry a cycle; the compare follows in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      searching <= 1'b0;
      pend      <= 1'b0;
      hit       <= 1'b0;
      rd_idx    <= '0;
    end else if (ctl.search_start) begin
      searching <= 1'b1;
      pend      <= 1'b0;
      hit       <= 1'b0;
      rd_idx    <= '0;
    end else if (ctl.commit) begin
      searching <= 1'b0;
      pend      <= 1'b0;
    end else if (searching) begin
      if (issue) begin
        rd_idx <= rd_idx + UW'(1);
      end
      pend <= issue;
      if (pend && (rdata == id_q)) begin
        hit <= 1'b1;
      end
    end
  end

  rsaf_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (PREVIEW_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (used[AW-1:0]),
    .wdata (id_q),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      status <= verdict;
    end
  end

  assign frame_total       = 32'(count);
  assign manifest_admitted = manifest_flag;
  assign is_hostless       = session_open_seen && hostless_flag;

endmodule

### rtl/recorded_stream_admission_filter.sv
// Admission filter for frames written to a recorded message file.
// An item (begin, finish or a classified frame) is presented on command,
// decode_ok, is_preview, arb_params and object_id, and is taken at a
// rising edge where start is high and busy is low. Each item gives exactly
// one result on status, frame_total, manifest_admitted and is_hostless, shown
// for one cycle while done is high.
// For most items the controller passes through its evaluate state once and done
// is then registered: busy is already low in the cycle where done is high, so a
// new item can be taken at the edge that ends it.
// A capture announce whose body decoded, while n > 0 preview streams are
// recorded, walks the preview table one entry a cycle through the table
// RAM's single registered read port, comparing each entry with the object ID.
// Reset (rst, synchronous) clears the session flags, the admitted-frame
// count and the preview table fill level; table contents need no clearing.
// The receiver cannot stall: each result must be taken in its done cycle.
module recorded_stream_admission_filter
  import rsaf_pkg::*;
#(
  parameter int PREVIEW_SLOTS = PREVIEW_SLOTS_DEF,
  parameter int ID_BITS       = ID_BITS_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  command,
  input  logic        decode_ok,
  input  logic        is_preview,
  input  logic        arb_params,
  input  logic [63:0] object_id,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] frame_total,
  output logic        manifest_admitted,
  output logic        is_hostless
);

  rsaf_cmd_t  ctl;
  rsaf_stat_t stat;

  rsaf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctl   (ctl)
  );

  rsaf_dp #(
    .PREVIEW_SLOTS (PREVIEW_SLOTS),
    .ID_BITS       (ID_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .command           (command),
    .decode_ok         (decode_ok),
    .is_preview        (is_preview),
    .arb_params        (arb_params),
    .object_id         (object_id),
    .ctl               (ctl),
    .stat              (stat),
    .status            (status),
    .frame_total       (frame_total),
    .manifest_admitted (manifest_admitted),
    .is_hostless       (is_hostless),
    .done              (done)
  );

endmodule

### rtl/rsaf_checker.sv
module rsaf_checker
  import rsaf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [31:0] frame_total,
  input logic        manifest_admitted
);

  // An accepted item keeps the block busy until its result is out.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // The result is shown only once the item is finished.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK) || (status == ST_REFUSED) || (status == ST_DECODE))
    else $error("status code out of range");

  // The frame count only moves with a result.
  a_total_moves: assert property (@(posedge clk) disable iff (rst)
    !$stable(frame_total) |-> done)
    else $error("frame count changed without a result");

  a_manifest_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(manifest_admitted) |-> done && (status == ST_OK))
    else $error("manifest flag rose without an admitted item");

endmodule

bind recorded_stream_admission_filter rsaf_checker u_rsaf_checker (.*);
